### design/assert_macros.svh
// Assertion macros shared by the calendar clock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CCC_ASSERT_IMP(lbl, ante, cons, msg)
`define CCC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### design/ccc_pkg.sv
// Types and constants of the calendar clock cascade.
package ccc_pkg;

  typedef enum logic [1:0] {
    FN_USEC = 2'd0,
    FN_MSEC = 2'd1,
    FN_ADD  = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  // Counter at which a single increment enters the cascade.
  typedef enum logic [1:0] {
    LV_USEC,
    LV_MSEC,
    LV_SEC
  } level_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  // Full calendar, plus residues of year and century kept alongside so that
  // the leap and carry tests need no division.
  typedef struct packed {
    logic [9:0]  usec;
    logic [9:0]  msec;
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] century;
    logic [15:0] millennium;
    logic [1:0]  year_m4;
    logic [6:0]  year_m100;
    logic [8:0]  year_m400;
    logic [3:0]  cent_m10;
  } cal_t;

  localparam logic [9:0]  USEC_TOP  = 10'd999;
  localparam logic [9:0]  MSEC_TOP  = 10'd999;
  localparam logic [5:0]  SEC_TOP   = 6'd59;
  localparam logic [5:0]  MIN_TOP   = 6'd59;
  localparam logic [4:0]  HOUR_TOP  = 5'd23;
  localparam logic [3:0]  MONTH_TOP = 4'd12;
  localparam logic [4:0]  FEB_DAYS  = 5'd28;
  localparam logic [4:0]  LEAP_FEB  = 5'd29;
  localparam logic [4:0]  SHORT_MON = 5'd30;
  localparam logic [4:0]  LONG_MON  = 5'd31;
  localparam logic [15:0] CNT_TOP   = 16'hFFFF;
  localparam logic [6:0]  M100_TOP  = 7'd99;
  localparam logic [8:0]  M400_TOP  = 9'd399;
  localparam logic [3:0]  M10_TOP   = 4'd9;
  localparam logic [16:0] MS_PER_S  = 17'd1000;

  localparam cal_t CAL_START = '{
    usec: 10'd0, msec: 10'd0, sec: 6'd0, minute: 6'd11, hour: 5'd12,
    day: 5'd22, month: 4'd9, year: 16'd17, century: 16'd20,
    millennium: 16'd0, year_m4: 2'd1, year_m100: 7'd17, year_m400: 9'd17,
    cent_m10: 4'd0
  };

endpackage

### design/ccc_step.sv
// Shared cascade unit: one increment of the calendar at a chosen counter.
module ccc_step (
  input  ccc_pkg::cal_t   cur,
  input  ccc_pkg::level_t lvl,
  output ccc_pkg::cal_t   nxt
);
  import ccc_pkg::*;

  always_comb begin
    logic       carry_ms;
    logic       carry_s;
    logic       carry_min;
    logic       carry_h;
    logic       carry_d;
    logic       carry_mo;
    logic       carry_y;
    logic       carry_c;
    logic       leap;
    logic [4:0] last_day;

    nxt       = cur;
    carry_ms  = (lvl == LV_MSEC);
    carry_s   = (lvl == LV_SEC);
    carry_min = 1'b0;
    carry_h   = 1'b0;
    carry_d   = 1'b0;
    carry_mo  = 1'b0;
    carry_y   = 1'b0;
    carry_c   = 1'b0;

    if (lvl == LV_USEC) begin
      if (cur.usec >= USEC_TOP) begin
        nxt.usec = '0;
        carry_ms = 1'b1;
      end else begin
        nxt.usec = cur.usec + 10'd1;
      end
    end

    if (carry_ms) begin
      if (cur.msec >= MSEC_TOP) begin
        nxt.msec = '0;
        carry_s  = 1'b1;
      end else begin
        nxt.msec = cur.msec + 10'd1;
      end
    end

    if (carry_s) begin
      if (cur.sec >= SEC_TOP) begin
        nxt.sec   = '0;
        carry_min = 1'b1;
      end else begin
        nxt.sec = cur.sec + 6'd1;
      end
    end

    if (carry_min) begin
      if (cur.minute >= MIN_TOP) begin
        nxt.minute = '0;
        carry_h    = 1'b1;
      end else begin
        nxt.minute = cur.minute + 6'd1;
      end
    end

    if (carry_h) begin
      if (cur.hour >= HOUR_TOP) begin
        nxt.hour = '0;
        carry_d  = 1'b1;
      end else begin
        nxt.hour = cur.hour + 5'd1;
      end
    end

    // Leap test on the year counter as it stands, through its residues.
    leap = ((cur.year_m4 == 2'd0) && (cur.year_m100 != 7'd0)) ||
           (cur.year_m400 == 9'd0);
    case (cur.month) inside
      4'd2:                   last_day = leap ? LEAP_FEB : FEB_DAYS;
      4'd4, 4'd6, 4'd9, 4'd11: last_day = SHORT_MON;
      default:                last_day = LONG_MON;
    endcase

    if (carry_d) begin
      if (cur.day >= last_day) begin
        nxt.day  = 5'd1;
        carry_mo = 1'b1;
      end else begin
        nxt.day = cur.day + 5'd1;
      end
    end

    if (carry_mo) begin
      if (cur.month >= MONTH_TOP) begin
        nxt.month = 4'd1;
        carry_y   = 1'b1;
      end else begin
        nxt.month = cur.month + 4'd1;
      end
    end

    // Year, century and millennium saturate; residues freeze with them.
    if (carry_y && (cur.year != CNT_TOP)) begin
      nxt.year      = cur.year + 16'd1;
      nxt.year_m4   = cur.year_m4 + 2'd1;
      nxt.year_m100 = (cur.year_m100 == M100_TOP) ? 7'd0 : cur.year_m100 + 7'd1;
      nxt.year_m400 = (cur.year_m400 == M400_TOP) ? 9'd0 : cur.year_m400 + 9'd1;
      carry_c       = (cur.year_m100 == M100_TOP);
    end

    if (carry_c && (cur.century != CNT_TOP)) begin
      nxt.century  = cur.century + 16'd1;
      nxt.cent_m10 = (cur.cent_m10 == M10_TOP) ? 4'd0 : cur.cent_m10 + 4'd1;
      if ((cur.cent_m10 == M10_TOP) && (cur.millennium != CNT_TOP)) begin
        nxt.millennium = cur.millennium + 16'd1;
      end
    end
  end

endmodule

### design/calendar_clock_cascade_core.sv
// Top level of the calendar clock cascade: sequencer, state and output register.
//
//  Channel  | Ports                   | Contents
//  ---------+-------------------------+------------------------------------------
//  input    | in_tvalid/tready/tdata  | tdata: ms_amount; tuser: func
//  result   | out_tvalid/tready/tdata | tdata: every calendar field, 96 bits
//
// An add request carries N whole seconds, N from 0 to 66, and the shared
// cascade unit applies one second per cycle until they are all folded in.
// Reset loads the fixed start date and empties the result register.
// A result waiting on out_tready does not block the next input transfer; only
// the load of the following result waits for the register to drain.
`include "assert_macros.svh"

module calendar_clock_cascade_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] ms_amount
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] usec_now, [19:10] msec_now, [25:20] sec_now, [31:26] min_now,
  // [36:32] hour_now, [41:37] day_now, [45:42] month_now, [61:46] year_now,
  // [77:62] century_now, [93:78] millennium_now, [95:94] zero
  output logic [95:0] out_tdata
);
  import ccc_pkg::*;

  state_t      state_r, state_nxt;
  cal_t        cal_r, cal_nxt;
  cal_t        out_cal_r, out_cal_nxt;
  logic        out_valid_r, out_valid_nxt;
  func_t       func_r, func_nxt;
  // Milliseconds still to fold: whole seconds are stripped one per cycle.
  logic [16:0] rem_r, rem_nxt;
  level_t      step_lvl;
  cal_t        step_cal;

  ccc_step u_step (
    .cur (cal_r),
    .lvl (step_lvl),
    .nxt (step_cal)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r       <= CAL_START;
      out_valid_r <= 1'b0;
    end else begin
      cal_r       <= cal_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_cal_r <= out_cal_nxt;
    func_r    <= func_nxt;
    rem_r     <= rem_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cal_nxt       = cal_r;
    rem_nxt       = rem_r;
    func_nxt      = func_r;
    out_cal_nxt   = out_cal_r;
    out_valid_nxt = out_valid_r;
    step_lvl      = LV_SEC;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = func_t'(in_tuser);
          rem_nxt   = {7'd0, cal_r.msec} + {1'b0, in_tdata};
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        case (func_r)
          FN_USEC: begin
            step_lvl  = LV_USEC;
            cal_nxt   = step_cal;
            state_nxt = S_EMIT;
          end
          FN_MSEC: begin
            step_lvl  = LV_MSEC;
            cal_nxt   = step_cal;
            state_nxt = S_EMIT;
          end
          FN_ADD: begin
            if (rem_r >= MS_PER_S) begin
              cal_nxt = step_cal;
              rem_nxt = rem_r - MS_PER_S;
            end else begin
              cal_nxt.msec = rem_r[9:0];
              state_nxt    = S_EMIT;
            end
          end
          default: begin
            // Unused function code: report the calendar unchanged.
            state_nxt = S_EMIT;
          end
        endcase
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cal_nxt   = cal_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cal_r.millennium, out_cal_r.century, out_cal_r.year,
                       out_cal_r.month, out_cal_r.day, out_cal_r.hour, out_cal_r.minute,
                       out_cal_r.sec, out_cal_r.msec, out_cal_r.usec};

  // A presented result always carries its usec to hour fields within their ranges.
  `CCC_ASSERT_IMP(a_out_range, out_valid_r, (out_cal_r.usec < 10'd1000) && (out_cal_r.msec < 10'd1000) && (out_cal_r.sec < 6'd60) && (out_cal_r.minute < 6'd60) && (out_cal_r.hour < 5'd24), "result field out of range")
  // Day never falls to zero and month stays within 1 to 12.
  `CCC_ASSERT_IMP(a_date_range, 1'b1, (cal_r.day != 5'd0) && (cal_r.month != 4'd0) && (cal_r.month <= MONTH_TOP), "day or month out of range")
  // Each add step strips exactly one second of milliseconds.
  `CCC_ASSERT_NXT(a_add_step, (state_r == S_RUN) && (func_r == FN_ADD) && (rem_r >= MS_PER_S), (state_r == S_RUN) && (rem_r == $past(rem_r) - MS_PER_S), "add step lost milliseconds")
  // An input transfer always starts a run.
  `CCC_ASSERT_NXT(a_accept_run, in_tvalid && in_tready, state_r == S_RUN, "transfer did not start a run")

endmodule

### dv/calendar_clock_cascade_core_tb.sv
// Self-checking testbench for the calendar clock cascade core.
module calendar_clock_cascade_core_tb;
  import ccc_pkg::*;

  // One queued stimulus item. A drain item is held back until every result
  // already owed by the block has arrived; calm items switch idling off.
  typedef struct {
    func_t       func;
    logic [15:0] amount;
    bit          drain;
    bit          calm;
  } clock_request_t;

  // The testbench's own copy of the calendar.
  typedef struct {
    logic [9:0]  usec;
    logic [9:0]  msec;
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic [15:0] century;
    logic [15:0] millennium;
  } clock_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] ms_amount
  logic [1:0]  in_tuser = '0;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [9:0] usec_now, [19:10] msec_now, [25:20] sec_now, [31:26] min_now,
  // [36:32] hour_now, [41:37] day_now, [45:42] month_now, [61:46] year_now,
  // [77:62] century_now, [93:78] millennium_now, [95:94] zero
  logic [95:0] out_tdata;

  clock_request_t request_queue[$];
  logic [95:0]    calendar_expect[$];
  clock_state_t   calendar;
  clock_request_t next_request;

  // Position, width and name of each field of a result, lowest bits first.
  int    field_lo [10] = '{0, 10, 20, 26, 32, 37, 42, 46, 62, 78};
  int    field_w [10] = '{10, 10, 6, 6, 5, 5, 4, 16, 16, 16};
  string field_name [10] = '{"usec", "msec", "sec", "min", "hour", "day", "month",
                             "year", "century", "millennium"};

  int gap_left = 0;
  int stall_left = 0;
  bit calm_phase = 1'b0;
  int mismatch_count = 0;
  int results_seen = 0;
  int add_transfers = 0;
  int tick_transfers = 0;
  int other_transfers = 0;

  calendar_clock_cascade_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // One second forward, carried up through the whole cascade. February is
  // tested for leap years on the year counter as it stands, and the three top
  // counters stick at their maximum, stopping any further carry.
  function automatic void advance_second();
    logic [4:0] month_len;
    logic       leap;
    if (calendar.sec < 6'd59) begin
      calendar.sec = calendar.sec + 6'd1;
      return;
    end
    calendar.sec = '0;
    if (calendar.minute < 6'd59) begin
      calendar.minute = calendar.minute + 6'd1;
      return;
    end
    calendar.minute = '0;
    if (calendar.hour < 5'd23) begin
      calendar.hour = calendar.hour + 5'd1;
      return;
    end
    calendar.hour = '0;
    leap = ((calendar.year % 16'd4 == 16'd0) && (calendar.year % 16'd100 != 16'd0)) ||
           (calendar.year % 16'd400 == 16'd0);
    if (calendar.month == 4'd2)
      month_len = leap ? 5'd29 : 5'd28;
    else if (calendar.month == 4'd4 || calendar.month == 4'd6 ||
             calendar.month == 4'd9 || calendar.month == 4'd11)
      month_len = 5'd30;
    else
      month_len = 5'd31;
    if (calendar.day < month_len) begin
      calendar.day = calendar.day + 5'd1;
      return;
    end
    calendar.day = 5'd1;
    if (calendar.month < 4'd12) begin
      calendar.month = calendar.month + 4'd1;
      return;
    end
    calendar.month = 4'd1;
    if (calendar.year == 16'hFFFF)
      return;
    calendar.year = calendar.year + 16'd1;
    if (calendar.year % 16'd100 != 16'd0 || calendar.century == 16'hFFFF)
      return;
    calendar.century = calendar.century + 16'd1;
    if (calendar.century % 16'd10 == 16'd0 && calendar.millennium != 16'hFFFF)
      calendar.millennium = calendar.millennium + 16'd1;
  endfunction

  function automatic void advance_msec();
    if (calendar.msec >= 10'd999) begin
      calendar.msec = '0;
      advance_second();
    end else begin
      calendar.msec = calendar.msec + 10'd1;
    end
  endfunction

  // Applies one accepted transfer to the calendar copy and returns the result
  // packed in the layout of out_tdata.
  function automatic logic [95:0] predict_calendar(func_t fn, logic [15:0] amount);
    logic [16:0] total_ms;
    logic [6:0]  whole_sec;
    case (fn)
      FN_USEC: begin
        if (calendar.usec >= 10'd999) begin
          calendar.usec = '0;
          advance_msec();
        end else begin
          calendar.usec = calendar.usec + 10'd1;
        end
      end
      FN_MSEC: advance_msec();
      FN_ADD: begin
        total_ms = 17'(calendar.msec) + 17'(amount);
        whole_sec = 7'(total_ms / 17'd1000);
        calendar.msec = 10'(total_ms % 17'd1000);
        repeat (whole_sec) advance_second();
      end
      default: ;
    endcase
    return {2'b00, calendar.millennium, calendar.century, calendar.year, calendar.month,
            calendar.day, calendar.hour, calendar.minute, calendar.sec, calendar.msec,
            calendar.usec};
  endfunction

  task automatic queue_request(input func_t fn, input logic [15:0] amount, input bit drain);
    clock_request_t req;
    req.func = fn;
    req.amount = amount;
    req.drain = drain;
    req.calm = 1'b0;
    request_queue.push_back(req);
  endtask

  // Driver: predicts on every accepted transfer, then offers the next item,
  // with occasional idle bursts and a hold wherever an item asks for a drain.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
      calendar = '{usec: 10'd0, msec: 10'd0, sec: 6'd0, minute: 6'd11, hour: 5'd12,
                   day: 5'd22, month: 4'd9, year: 16'd17, century: 16'd20,
                   millennium: 16'd0};
    end else begin
      if (in_tvalid && in_tready) begin
        calendar_expect.push_back(predict_calendar(func_t'(in_tuser), in_tdata));
        case (func_t'(in_tuser))
          FN_ADD:           add_transfers++;
          FN_USEC, FN_MSEC: tick_transfers++;
          default:          other_transfers++;
        endcase
      end
      if (in_tvalid && !in_tready) begin
        // The offered item stays on the bus until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (request_queue.size() == 0 ||
                   (request_queue[0].drain && calendar_expect.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        next_request = request_queue.pop_front();
        in_tuser <= next_request.func;
        in_tdata <= next_request.amount;
        in_tvalid <= 1'b1;
        if (next_request.calm)
          calm_phase = 1'b1;
        else if ($urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 12);
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation, field
  // by field, and stalls the result channel in random bursts.
  always @(posedge clk) begin
    logic [95:0] wanted;
    logic [15:0] field_mask;
    logic [15:0] want_field;
    logic [15:0] got_field;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (calendar_expect.size() == 0) begin
          if (mismatch_count < 10)
            $display("Result %0d arrived with nothing expected: %h", results_seen,
                     out_tdata);
          mismatch_count++;
        end else begin
          wanted = calendar_expect.pop_front();
          for (int f = 0; f < 10; f++) begin
            field_mask = 16'((17'h1 << field_w[f]) - 17'h1);
            want_field = 16'(wanted >> field_lo[f]) & field_mask;
            got_field = 16'(out_tdata >> field_lo[f]) & field_mask;
            if (want_field !== got_field) begin
              if (mismatch_count < 10)
                $display("Result %0d, field %s: expected %0d, got %0d", results_seen,
                         field_name[f], want_field, got_field);
              mismatch_count++;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 9) == 0)
          stall_left = $urandom_range(1, 12);
      end
    end
  end

  // Stimulus, reset and the final verdict.
  initial begin
    int          pick;
    logic [15:0] amount;
    longint      added_ms;
    int          usec_ticks;

    // Directed opening: the unused code, ignored amounts on ticks, a
    // millisecond tick that rolls the second, an exact second, a run of
    // seconds across the minute and the largest possible add (999 + 65535 ms,
    // so 66 seconds inside one transfer).
    queue_request(FN_NONE, 16'hFFFF, 1'b0);
    queue_request(FN_USEC, 16'h0000, 1'b0);
    queue_request(FN_MSEC, 16'h0000, 1'b0);
    queue_request(FN_ADD, 16'd0, 1'b0);
    queue_request(FN_ADD, 16'd998, 1'b0);
    queue_request(FN_MSEC, 16'hFFFF, 1'b0);
    queue_request(FN_ADD, 16'd999, 1'b0);
    queue_request(FN_ADD, 16'hFFFF, 1'b0);
    queue_request(FN_ADD, 16'd1000, 1'b0);
    queue_request(FN_ADD, 16'd59000, 1'b0);
    queue_request(FN_NONE, 16'h0000, 1'b0);
    queue_request(FN_ADD, 16'h5555, 1'b0);
    queue_request(FN_ADD, 16'hAAAA, 1'b0);
    queue_request(FN_USEC, 16'hFFFF, 1'b0);
    queue_request(FN_MSEC, 16'h8000, 1'b0);
    queue_request(FN_ADD, 16'd1, 1'b0);

    // First random phase: mostly large adds. From the start time of 12:11
    // the calendar needs about 42.5 million ms to pass midnight, so the phase
    // runs until a little more than that has been added, which also rolls
    // the day. The first add of the phase waits for the directed part to drain.
    added_ms = 0;
    while (added_ms < 64'd43_000_000) begin
      pick = $urandom_range(0, 99);
      if (pick < 93) begin
        if ($urandom_range(0, 99) < 85)
          amount = 16'($urandom_range(60000, 65535));
        else
          amount = 16'($urandom_range(0, 65535));
        added_ms += longint'(amount);
        queue_request(FN_ADD, amount,
                      added_ms == longint'(amount) || $urandom_range(0, 199) == 0);
      end else if (pick < 96) begin
        queue_request(FN_MSEC, 16'($urandom_range(0, 65535)), 1'b0);
      end else if (pick < 98) begin
        queue_request(FN_USEC, 16'($urandom_range(0, 65535)), 1'b0);
      end else begin
        queue_request(FN_NONE, 16'($urandom_range(0, 65535)), 1'b0);
      end
    end

    // Second random phase: enough microsecond ticks to wrap the microsecond
    // counter, with a little noise of other kinds mixed in.
    usec_ticks = 0;
    while (usec_ticks < 1020) begin
      pick = $urandom_range(0, 99);
      amount = 16'($urandom_range(0, 65535));
      if (pick < 96) begin
        usec_ticks++;
        queue_request(FN_USEC, amount, 1'b0);
      end else if (pick < 98) begin
        queue_request(FN_ADD, amount, $urandom_range(0, 199) == 0);
      end else if (pick < 99) begin
        queue_request(FN_MSEC, amount, 1'b0);
      end else begin
        queue_request(FN_NONE, amount, 1'b0);
      end
    end

    // No idling on either side for the tail of the run.
    for (int i = request_queue.size() - 150; i < request_queue.size(); i++)
      request_queue[i].calm = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || in_tvalid || calendar_expect.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    if (calendar_expect.size() != 0) begin
      $display("%0d expected results never arrived", calendar_expect.size());
      mismatch_count += calendar_expect.size();
    end

    $display("Covered %0d add requests, %0d tick transfers and %0d unused-code transfers;",
             add_transfers, tick_transfers, other_transfers);
    $display("%0d results checked, calendar ended at day %0d month %0d, %0d:%0d:%0d.",
             results_seen, calendar.day, calendar.month, calendar.hour, calendar.minute,
             calendar.sec);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Run timed out");
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/ccc_pkg.sv
design/ccc_step.sv
design/calendar_clock_cascade_core.sv
dv/calendar_clock_cascade_core_tb.sv
